### hdl/gha_pkg.sv
// Shared types, constants and helpers for the generational handle allocator.
// No dependencies; imported by gha_gen_mem, gha_core and the top level.
package gha_pkg;

  localparam int SLOTS    = 64;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int GEN_W    = 32;
  localparam int HANDLE_W = 64;
  localparam int IDX_W    = 6;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;

  // Allocation scan looks at one group of alive bits per cycle
  localparam int GRP_LOG = 3;
  localparam int GRP     = 1 << GRP_LOG;
  localparam int NGRP    = (SLOTS + GRP - 1) / GRP;
  localparam int PAD_W   = NGRP * GRP;
  localparam int GRP_W   = (NGRP > 1) ? $clog2(NGRP) : 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RESOLVE = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_AFIN,
    S_CHECK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [HANDLE_W-1:0] handle;
    logic [IDX_W-1:0]    idx;
  } res_t;

  // Low bits of a slot number as carried on slot_index
  function automatic logic [IDX_W-1:0] slot_to_idx(input logic [SLOT_W-1:0] slot);
    logic [31:0] t;
    t = 32'(slot);
    return t[IDX_W-1:0];
  endfunction

endpackage

### hdl/gha_gen_mem.sv
// Generation store: one 32-bit counter per slot, single write and read port.
// Per-entry written bits make unwritten entries read as zero after reset.
// Depends on gha_pkg.
module gha_gen_mem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [gha_pkg::SLOT_W-1:0] rd_addr,
  output logic [gha_pkg::GEN_W-1:0]  rd_data,
  input  logic                       wr_en,
  input  logic [gha_pkg::SLOT_W-1:0] wr_addr,
  input  logic [gha_pkg::GEN_W-1:0]  wr_data
);
  import gha_pkg::*;

  logic [GEN_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0] written_r;
  logic [GEN_W-1:0] mem_q_r;
  logic             wv_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      wv_q_r    <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        wv_q_r <= written_r[rd_addr];
      end
    end
  end

  assign rd_data = wv_q_r ? mem_q_r : '0;

endmodule

### hdl/gha_core.sv
// Sequencer, alive bitmap and group scan unit of the handle allocator.
// Depends on gha_pkg and gha_gen_mem.
module gha_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [gha_pkg::CMD_W-1:0]    cmd,
  input  logic [gha_pkg::HANDLE_W-1:0] handle,
  output logic                         idle,
  output logic                         res_valid,
  output gha_pkg::res_t                res,
  input  logic                         res_take
);
  import gha_pkg::*;

  state_t              state_r, state_nxt;
  logic [CMD_W-1:0]    cmd_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [GRP_W-1:0]    grp_r;
  logic [SLOTS-1:0]    alive_r;
  res_t                res_r;

  // Scan unit
  logic [PAD_W-1:0]   alive_pad;
  logic [GRP-1:0]     grp_bits;
  logic [GRP_LOG-1:0] pe;
  logic               found;
  logic [SLOT_W-1:0]  found_slot;
  logic               last_grp;

  // Handle check
  logic [31:0]       lo;
  logic              range_ok;
  logic [SLOT_W-1:0] dec_slot;
  logic              cmd_chk;
  logic              match;

  // Memory and bitmap controls
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic [GEN_W-1:0]  rd_data;
  logic              wr_en;
  logic              alive_set;
  logic              alive_clr;

  always_comb begin
    alive_pad = '1;
    for (int i = 0; i < SLOTS; i++) begin
      alive_pad[i] = alive_r[i];
    end
  end

  assign grp_bits = alive_pad[{grp_r, GRP_LOG'(0)} +: GRP];

  always_comb begin
    pe = '0;
    for (int i = GRP - 1; i >= 0; i--) begin
      if (!grp_bits[i]) begin
        pe = GRP_LOG'(i);
      end
    end
  end

  assign found      = ~&grp_bits;
  assign found_slot = SLOT_W'({grp_r, pe});
  assign last_grp   = (grp_r == GRP_W'(NGRP - 1));

  assign lo       = handle_r[31:0];
  assign range_ok = (lo != 32'd0) && (lo <= 32'(SLOTS));
  assign dec_slot = SLOT_W'(lo - 32'd1);
  assign cmd_chk  = (cmd_r == CMD_FREE) || (cmd_r == CMD_RESOLVE);
  assign match    = alive_r[slot_r] && (handle_r[63:32] == rd_data);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = (cmd == CMD_ALLOC) ? S_SCAN : S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = (cmd_chk && range_ok) ? S_CHECK : S_RESP;
      end
      S_SCAN: begin
        if (found) begin
          state_nxt = S_AFIN;
        end else if (last_grp) begin
          state_nxt = S_RESP;
        end
      end
      S_AFIN:  state_nxt = S_RESP;
      S_CHECK: state_nxt = S_RESP;
      S_RESP: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs and controls
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = slot_r;
    wr_en     = 1'b0;
    alive_set = 1'b0;
    alive_clr = 1'b0;
    idle      = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      S_IDLE: idle = 1'b1;
      S_DECODE: begin
        rd_en   = cmd_chk && range_ok;
        rd_addr = dec_slot;
      end
      S_SCAN: begin
        rd_en     = found;
        rd_addr   = found_slot;
        alive_set = found;
      end
      S_CHECK: begin
        alive_clr = match && (cmd_r == CMD_FREE);
        wr_en     = alive_clr;
      end
      S_RESP:  res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      alive_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (alive_set) begin
        alive_r[found_slot] <= 1'b1;
      end
      if (alive_clr) begin
        alive_r[slot_r] <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_r    <= cmd;
          handle_r <= handle;
          grp_r    <= '0;
        end
      end
      S_DECODE: begin
        slot_r <= dec_slot;
        if (!(cmd_chk && range_ok)) begin
          res_r <= '{status: STAT_BAD, handle: '0, idx: '0};
        end
      end
      S_SCAN: begin
        slot_r <= found_slot;
        grp_r  <= grp_r + GRP_W'(1);
        if (!found && last_grp) begin
          res_r <= '{status: STAT_FULL, handle: '0, idx: '0};
        end
      end
      S_AFIN: begin
        res_r <= '{status: STAT_OK,
                   handle: {rd_data, 32'(slot_r) + 32'd1},
                   idx:    slot_to_idx(slot_r)};
      end
      S_CHECK: begin
        if (match) begin
          res_r <= '{status: STAT_OK, handle: '0, idx: slot_to_idx(slot_r)};
        end else begin
          res_r <= '{status: STAT_BAD, handle: '0, idx: '0};
        end
      end
      default: ;
    endcase
  end

  assign res = res_r;

  gha_gen_mem u_gen_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (slot_r),
    .wr_data (rd_data + GEN_W'(1))
  );

endmodule

### hdl/generational_handle_allocator.sv
// Generational handle allocator: a table of SLOTS entries (64), each with an
// alive bit and a 32-bit generation. Handles carry the generation in bits
// 63..32 and slot+1 in bits 31..0.
// Input channel in_valid/in_stall carries in_command (0 allocate, 1 free,
// 2 resolve) and in_handle_in. Each transfer yields exactly one result on
// out_valid/out_stall: out_status, out_handle_out, out_slot_index.
// One item is processed at a time; in_stall is high while it is in work and
// drops in the cycle after the result moves on.
// Free / resolve decode the slot field and read its generation; with the slot
// field out of range or an unused command the check is skipped (status bad).
// Allocate scans the alive bitmap in groups of 8, 8 slots a cycle, from slot
// 0 up until a free slot is seen; with the table full every group is scanned
// and the status is full.
// A finished result moves into the output register, and the next item is
// accepted while it waits there; a stalled result holds its value.
// Reset (synchronous, rst_n low) clears all alive bits and generations and
// empties the output register; the block is ready in the next cycle.
// Depends on gha_pkg and gha_core.
module generational_handle_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [gha_pkg::CMD_W-1:0]    in_command,
  input  logic [gha_pkg::HANDLE_W-1:0] in_handle_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gha_pkg::STAT_W-1:0]   out_status,
  output logic [gha_pkg::HANDLE_W-1:0] out_handle_out,
  output logic [gha_pkg::IDX_W-1:0]    out_slot_index
);
  import gha_pkg::*;

  logic idle;
  logic start;
  logic res_valid;
  res_t res;
  logic load;
  logic out_valid_r, out_valid_nxt;
  res_t out_r;

  assign in_stall = !idle;
  assign start    = in_valid && idle;
  assign load     = res_valid && (!out_valid_r || !out_stall);

  gha_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cmd       (in_command),
    .handle    (in_handle_in),
    .idle      (idle),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (load)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_r.status;
  assign out_handle_out = out_r.handle;
  assign out_slot_index = out_r.idx;

endmodule

### dv/tb_generational_handle_allocator.sv
// Testbench for generational_handle_allocator: directed and random allocate,
// free and resolve traffic, checked against an in-bench copy of the slot table.
// Depends on gha_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb_generational_handle_allocator;
  import gha_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 3 + NGRP + 40;
  localparam int HOLD_CYCLES    = 200;
  localparam int N_RANDOM       = 1650;
  // encoding with no operation behind it
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    in_command   = CMD_ALLOC;
  logic [HANDLE_W-1:0] in_handle_in = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [STAT_W-1:0]   out_status;
  logic [HANDLE_W-1:0] out_handle_out;
  logic [IDX_W-1:0]    out_slot_index;

  // copy of the slot table, advanced as each command is accepted
  logic             alive_map [SLOTS];
  logic [GEN_W-1:0] gen_map   [SLOTS];
  res_t             pending_results [$];

  int errors      = 0;
  int idle_cycles = 0;
  bit quiet_in    = 1'b0;
  bit quiet_out   = 1'b0;
  bit hold_req    = 1'b0;

  generational_handle_allocator u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_handle_in   (in_handle_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_handle_out (out_handle_out),
    .out_slot_index (out_slot_index)
  );

  always #10 clk = ~clk;

  function automatic res_t slot_table_apply(input logic [CMD_W-1:0]    cmd,
                                            input logic [HANDLE_W-1:0] h);
    res_t        r;
    logic [31:0] slot_plus1;
    int          s;
    bit          hit;
    r.status   = STAT_BAD;
    r.handle   = '0;
    r.idx      = '0;
    hit        = 1'b0;
    s          = 0;
    slot_plus1 = h[31:0];
    if (cmd == CMD_ALLOC) begin
      r.status = STAT_FULL;
      for (int i = 0; i < SLOTS; i++) begin
        if (!hit && !alive_map[i]) begin
          hit = 1'b1;
          s   = i;
        end
      end
      if (hit) begin
        alive_map[s] = 1'b1;
        r.status     = STAT_OK;
        r.handle     = {gen_map[s], 32'(s + 1)};
        r.idx        = IDX_W'(s);
      end
    end else if (cmd == CMD_FREE || cmd == CMD_RESOLVE) begin
      if (slot_plus1 != 0 && slot_plus1 <= SLOTS) begin
        s   = int'(slot_plus1) - 1;
        hit = alive_map[s] && (h[63:32] == gen_map[s]);
      end
      if (hit) begin
        r.status = STAT_OK;
        r.idx    = IDX_W'(s);
        if (cmd == CMD_FREE) begin
          alive_map[s] = 1'b0;
          gen_map[s]   = gen_map[s] + 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Slot pick biased toward live entries; stale when the table is empty
  function automatic int pick_slot();
    int start;
    start = $urandom_range(0, SLOTS - 1);
    for (int i = 0; i < SLOTS; i++) begin
      if (alive_map[(start + i) % SLOTS]) return (start + i) % SLOTS;
    end
    return start;
  endfunction

  function automatic logic [HANDLE_W-1:0] current_handle(input int s);
    return {gen_map[s], 32'(s + 1)};
  endfunction

  // Entered at a falling edge; returns at the falling edge after the transfer
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [HANDLE_W-1:0] h);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_command   = cmd;
    in_handle_in = h;
    in_valid     = 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(slot_table_apply(cmd, h));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    send_cmd(CMD_RESOLVE, '0);
    send_cmd(CMD_FREE, '0);
    send_cmd(CMD_SPARE, {$urandom, $urandom});
    send_cmd(CMD_ALLOC, '1);
    send_cmd(CMD_RESOLVE, {32'd0, 32'd1});
    send_cmd(CMD_RESOLVE, {32'd1, 32'd1});
    send_cmd(CMD_RESOLVE, {32'hFFFF_FFFF, 32'd1});
    send_cmd(CMD_RESOLVE, {32'd0, 32'(SLOTS + 1)});
    send_cmd(CMD_RESOLVE, {32'd0, 32'(SLOTS)});
    send_cmd(CMD_RESOLVE, {32'd0, 32'hFFFF_FFFF});
    send_cmd(CMD_FREE, {32'd0, 32'd1});
    send_cmd(CMD_FREE, {32'd0, 32'd1});
    send_cmd(CMD_RESOLVE, {32'd0, 32'd1});
    send_cmd(CMD_ALLOC, '0);
    send_cmd(CMD_RESOLVE, {32'd1, 32'd1});
    send_cmd(CMD_SPARE, {32'd1, 32'd1});
    send_cmd(CMD_FREE, {32'd1, 32'd1});
    send_cmd(CMD_ALLOC, {$urandom, $urandom});
    send_cmd(CMD_ALLOC, {$urandom, $urandom});
    send_cmd(CMD_FREE, {32'd2, 32'd1});
    send_cmd(CMD_FREE, current_handle(1));
    send_cmd(CMD_FREE, current_handle(0));
    wait_drained();
  endtask

  // Fill past full, resolve, free each slot in shuffled order (4 allocs halfway)
  task automatic test_fill_and_empty();
    int order [SLOTS];
    int j;
    int t;
    quiet_in = 1'b1;
    repeat (SLOTS + 3) send_cmd(CMD_ALLOC, {$urandom, $urandom});
    quiet_in = 1'b0;
    repeat (8) send_cmd(CMD_RESOLVE, current_handle($urandom_range(0, SLOTS - 1)));
    for (int i = 0; i < SLOTS; i++) order[i] = i;
    for (int i = SLOTS - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < SLOTS; i++) begin
      send_cmd(CMD_FREE, current_handle(order[i]));
      if (i == SLOTS / 2) repeat (4) send_cmd(CMD_ALLOC, '0);
    end
    send_cmd(CMD_RESOLVE, {32'd1, 32'(SLOTS)});
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps offering, so in_stall must rise
  task automatic test_backpressure();
    quiet_in = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 16; i++) begin
      if (i % 3 == 2) send_cmd(CMD_RESOLVE, current_handle(pick_slot()));
      else send_cmd(CMD_ALLOC, {$urandom, $urandom});
    end
    quiet_in = 1'b0;
    wait_drained();
  endtask

  task automatic test_random();
    int                  alloc_pct;
    int                  k;
    int                  s;
    logic [GEN_W-1:0]    g;
    logic [CMD_W-1:0]    cmd;
    logic [HANDLE_W-1:0] h;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 150 == 0) begin
        quiet_in  = ($urandom_range(0, 3) == 0);
        quiet_out = ($urandom_range(0, 3) == 0);
      end
      // alternate between filling and draining phases
      alloc_pct = ((n / 200) % 2) ? 60 : 25;
      cmd = ($urandom_range(0, 1) == 0) ? CMD_FREE : CMD_RESOLVE;
      if ($urandom_range(0, 99) < alloc_pct) begin
        send_cmd(CMD_ALLOC, {$urandom, $urandom});
      end else begin
        k = $urandom_range(0, 9);
        s = pick_slot();
        if (k < 4) begin
          send_cmd(CMD_FREE, current_handle(s));
        end else if (k < 7) begin
          send_cmd(CMD_RESOLVE, current_handle(s));
        end else if (k == 7) begin
          g = $urandom_range(0, 1) ? gen_map[s] + 1'b1 : gen_map[s] - 1'b1;
          send_cmd(cmd, {g, 32'(s + 1)});
        end else if (k == 8) begin
          send_cmd(cmd, {$urandom, $urandom});
        end else begin
          case ($urandom_range(0, 3))
            0: h = {gen_map[s], 32'd0};
            1: h = {gen_map[s], 32'(SLOTS + 1)};
            2: h = {gen_map[s], 32'hFFFF_FFFF};
            default: begin
              h   = current_handle(s);
              cmd = CMD_SPARE;
            end
          endcase
          send_cmd(cmd, h);
        end
      end
    end
    quiet_in  = 1'b0;
    quiet_out = 1'b0;
    wait_drained();
  endtask

  // Result side: random hold-off before each transfer, plus a long hold on request
  initial begin : result_sink
    int w;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      w = quiet_out ? 0 : $urandom_range(0, 17);
      if (w > 0) begin
        out_stall = 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid && !hold_req);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result with nothing outstanding: status %0d handle %h slot %0d",
                   out_status, out_handle_out, out_slot_index);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_handle_out !== want.handle ||
            out_slot_index !== want.idx) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: status %0d/%0d handle %h/%h slot %0d/%0d (exp/got)",
                     want.status, out_status, want.handle, out_handle_out,
                     want.idx, out_slot_index);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_generational_handle_allocator: errors");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      alive_map[i] = 1'b0;
      gen_map[i]   = '0;
    end
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_fill_and_empty();
    test_backpressure();
    test_random();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_generational_handle_allocator: clean");
    end else begin
      $display("tb_generational_handle_allocator: errors");
    end
    $finish;
  end

endmodule

### sim.f
hdl/gha_pkg.sv
hdl/gha_gen_mem.sv
hdl/gha_core.sv
hdl/generational_handle_allocator.sv
dv/tb_generational_handle_allocator.sv
